>>> hdl/buddy_block_allocator_defines.svh
// Assertion macros shared by the buddy block allocator modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BBA_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BBA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/bba_pkg.sv
// Shared types, constants and helper functions of the buddy block allocator.
// Depends on nothing; used by bba_seq, the top level and the testbench.
`timescale 1ns / 1ps

package bba_pkg;

   localparam int MinBlockOrder  = 4;
   localparam int OrderSlots     = 12;
   localparam int HeapOrderCap   = 15;
   localparam int UnitBits       = HeapOrderCap - MinBlockOrder;
   localparam int SlotBits       = 4;
   localparam int OrderBits      = 5;
   localparam int LenBits        = UnitBits + 1;
   localparam int HeaderBytes    = 8;
   localparam int SizeOrderLimit = 20;
   localparam int ReqBits        = 16;
   localparam int OffsetBits     = 15;
   localparam int UsedBits       = 16;
   localparam int HeapOrderBits  = 4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef logic [UnitBits-1:0]      unit_type;
   typedef logic [SlotBits-1:0]      slot_type;
   typedef logic [OrderBits-1:0]     order_type;
   typedef logic [LenBits-1:0]       len_type;
   typedef logic [HeapOrderBits-1:0] heap_order_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NO_MEMORY,
      STATUS_BAD_SIZE,
      STATUS_BAD_FREE
   } status_type;

   typedef struct packed {
      logic           write;
      heap_order_type top_order;
   } cfg_type;

   typedef struct packed {
      logic                  done;
      status_type            status;
      logic [OffsetBits-1:0] offset;
      logic [UsedBits-1:0]   used;
   } rsp_type;

   // The heap order in use, saturated to the supported range.
   function automatic heap_order_type eff_order(input heap_order_type value);
      heap_order_type result;
      result = value;
      if (value < heap_order_type'(MinBlockOrder)) begin
         result = heap_order_type'(MinBlockOrder);
      end
      return result;
   endfunction

endpackage

>>> hdl/bba_ram.sv
// Generic single-write, single-read memory with registered read data.
// Depends on nothing; used for the link, order and live-mark stores.
`timescale 1ns / 1ps

module bba_ram #(
   parameter int AddrBits = 11,
   parameter int DataBits = 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [DataBits-1:0] wr_data,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [DataBits-1:0] rd_data
);

   logic [DataBits-1:0] mem [2**AddrBits];
   logic [DataBits-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bba_seq.sv
// Sequencer of the buddy allocator: sizing, list search, split, merge and free.
// Depends on bba_pkg and bba_ram; assertion macros from the defines header.
`timescale 1ns / 1ps
`include "buddy_block_allocator_defines.svh"

module bba_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              req_op,
   input  logic [bba_pkg::ReqBits-1:0]       req_request_bytes,
   input  logic [bba_pkg::OffsetBits-1:0]    req_block_offset,
   input  bba_pkg::cfg_type                  cfg,
   output logic                              busy,
   output bba_pkg::rsp_type                  rsp
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_A_SIZE,
      ST_A_FIND,
      ST_A_SPLIT_RD,
      ST_A_SPLIT_WR,
      ST_A_SPLIT_PUSH,
      ST_A_POP_RD,
      ST_A_POP_WR,
      ST_F_CHECK,
      ST_F_MERGE,
      ST_F_WALK_RD,
      ST_F_WALK,
      ST_F_PUSH
   } state_type;

   state_type                          state_ff, state_in;
   logic [bba_pkg::ReqBits-1:0]        req_ff, req_in;
   bba_pkg::order_type                 order_ff, order_in;
   bba_pkg::order_type                 j_ff, j_in;
   bba_pkg::unit_type                  unit_ff, unit_in;
   bba_pkg::unit_type                  b_ff, b_in;
   bba_pkg::unit_type                  cur_ff, cur_in;
   bba_pkg::unit_type                  prev_ff, prev_in;
   bba_pkg::unit_type                  clr_ff, clr_in;
   bba_pkg::len_type                   k_ff, k_in;
   bba_pkg::unit_type                  heads_ff [bba_pkg::OrderSlots];
   bba_pkg::unit_type                  heads_in [bba_pkg::OrderSlots];
   bba_pkg::len_type                   lens_ff [bba_pkg::OrderSlots];
   bba_pkg::len_type                   lens_in [bba_pkg::OrderSlots];
   logic [bba_pkg::UsedBits-1:0]       used_ff, used_in;
   logic                               done_ff, done_in;
   bba_pkg::status_type                status_ff, status_in;
   logic [bba_pkg::OffsetBits-1:0]     offset_ff, offset_in;

   logic                               next_we;
   bba_pkg::unit_type                  next_waddr, next_wdata, next_raddr, next_rdata;
   logic                               live_we, live_wdata, live_rdata;
   bba_pkg::unit_type                  live_waddr, info_raddr;
   logic                               ord_we;
   bba_pkg::unit_type                  ord_waddr;
   bba_pkg::heap_order_type            ord_wdata, ord_rdata;

   logic [bba_pkg::ReqBits:0]          need;
   logic [bba_pkg::SizeOrderLimit:0]   pow_order;
   bba_pkg::order_type                 top5;
   bba_pkg::slot_type                  slot_j, slot_jm1, slot_o;
   bba_pkg::unit_type                  half_unit, bud_unit;
   logic [bba_pkg::UsedBits-1:0]       used_delta;
   bba_pkg::order_type                 freed_order;
   bba_pkg::order_type                 j_dec;

   bba_ram #(.AddrBits(bba_pkg::UnitBits), .DataBits(bba_pkg::UnitBits)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (next_raddr),
      .rd_data (next_rdata)
   );

   bba_ram #(.AddrBits(bba_pkg::UnitBits), .DataBits(1)) u_live_ram (
      .clock   (clock),
      .wr_en   (live_we),
      .wr_addr (live_waddr),
      .wr_data (live_wdata),
      .rd_addr (info_raddr),
      .rd_data (live_rdata)
   );

   bba_ram #(.AddrBits(bba_pkg::UnitBits), .DataBits(bba_pkg::HeapOrderBits)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (info_raddr),
      .rd_data (ord_rdata)
   );

   assign need       = (bba_pkg::ReqBits+1)'(req_ff) + (bba_pkg::ReqBits+1)'(bba_pkg::HeaderBytes);
   assign pow_order  = (bba_pkg::SizeOrderLimit+1)'(1) << order_ff;
   assign top5       = bba_pkg::order_type'(cfg.top_order);
   assign slot_j     = bba_pkg::slot_type'(j_ff - bba_pkg::order_type'(bba_pkg::MinBlockOrder));
   assign slot_jm1   = slot_j - bba_pkg::slot_type'(1);
   assign slot_o     = bba_pkg::slot_type'(order_ff - bba_pkg::order_type'(bba_pkg::MinBlockOrder));
   assign half_unit  = bba_pkg::unit_type'(1) << slot_jm1;
   assign bud_unit   = unit_ff ^ (bba_pkg::unit_type'(1) << slot_o);
   assign used_delta = bba_pkg::UsedBits'(1) << order_ff;
   assign j_dec      = j_ff - bba_pkg::order_type'(1);

   always_comb begin
      freed_order = bba_pkg::order_type'(ord_rdata);
      if (freed_order < bba_pkg::order_type'(bba_pkg::MinBlockOrder)) begin
         freed_order = bba_pkg::order_type'(bba_pkg::MinBlockOrder);
      end
      if (freed_order > top5) begin
         freed_order = top5;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      order_in   = order_ff;
      j_in       = j_ff;
      unit_in    = unit_ff;
      b_in       = b_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      clr_in     = clr_ff;
      k_in       = k_ff;
      heads_in   = heads_ff;
      lens_in    = lens_ff;
      used_in    = used_ff;
      done_in    = 1'b0;
      status_in  = status_ff;
      offset_in  = offset_ff;
      next_we    = 1'b0;
      next_waddr = b_ff;
      next_wdata = heads_ff[slot_jm1];
      next_raddr = cur_ff;
      live_we    = 1'b0;
      live_waddr = unit_ff;
      live_wdata = 1'b0;
      ord_we     = 1'b0;
      ord_waddr  = b_ff;
      ord_wdata  = bba_pkg::heap_order_type'(order_ff);
      info_raddr = unit_ff;

      case (state_ff)
         ST_IDLE: begin
            info_raddr = req_block_offset[bba_pkg::OffsetBits-1:bba_pkg::MinBlockOrder];
            if (start) begin
               req_in  = req_request_bytes;
               unit_in = req_block_offset[bba_pkg::OffsetBits-1:bba_pkg::MinBlockOrder];
               if (req_op == bba_pkg::OP_ALLOC) begin
                  order_in = bba_pkg::order_type'(bba_pkg::MinBlockOrder);
                  state_in = ST_A_SIZE;
               end else if (req_block_offset[bba_pkg::MinBlockOrder-1:0] != '0 ||
                            (req_block_offset >> cfg.top_order) != '0) begin
                  done_in   = 1'b1;
                  status_in = bba_pkg::STATUS_BAD_FREE;
                  offset_in = '0;
               end else begin
                  state_in = ST_F_CHECK;
               end
            end
         end
         ST_CLEAR: begin
            live_we    = 1'b1;
            live_waddr = clr_ff;
            live_wdata = 1'b0;
            clr_in     = clr_ff + bba_pkg::unit_type'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_A_SIZE: begin
            if (order_ff < bba_pkg::order_type'(bba_pkg::SizeOrderLimit) &&
                pow_order < (bba_pkg::SizeOrderLimit+1)'(need)) begin
               order_in = order_ff + bba_pkg::order_type'(1);
            end else if (req_ff == '0 || order_ff > top5) begin
               done_in   = 1'b1;
               status_in = bba_pkg::STATUS_BAD_SIZE;
               offset_in = '0;
               state_in  = ST_IDLE;
            end else begin
               j_in     = order_ff;
               state_in = ST_A_FIND;
            end
         end
         ST_A_FIND: begin
            if (j_ff > top5) begin
               done_in   = 1'b1;
               status_in = bba_pkg::STATUS_NO_MEMORY;
               offset_in = '0;
               state_in  = ST_IDLE;
            end else if (lens_ff[slot_j] == '0) begin
               j_in = j_ff + bba_pkg::order_type'(1);
            end else if (j_ff == order_ff) begin
               state_in = ST_A_POP_RD;
            end else begin
               state_in = ST_A_SPLIT_RD;
            end
         end
         ST_A_SPLIT_RD: begin
            next_raddr = heads_ff[slot_j];
            b_in       = heads_ff[slot_j];
            state_in   = ST_A_SPLIT_WR;
         end
         ST_A_SPLIT_WR: begin
            heads_in[slot_j] = next_rdata;
            lens_in[slot_j]  = lens_ff[slot_j] - bba_pkg::len_type'(1);
            next_we          = 1'b1;
            next_waddr       = b_ff + half_unit;
            next_wdata       = heads_ff[slot_jm1];
            state_in         = ST_A_SPLIT_PUSH;
         end
         ST_A_SPLIT_PUSH: begin
            next_we            = 1'b1;
            next_waddr         = b_ff;
            next_wdata         = b_ff + half_unit;
            heads_in[slot_jm1] = b_ff;
            lens_in[slot_jm1]  = lens_ff[slot_jm1] + bba_pkg::len_type'(2);
            j_in               = j_dec;
            if (j_dec == order_ff) begin
               state_in = ST_A_POP_RD;
            end else begin
               state_in = ST_A_SPLIT_RD;
            end
         end
         ST_A_POP_RD: begin
            next_raddr = heads_ff[slot_o];
            b_in       = heads_ff[slot_o];
            state_in   = ST_A_POP_WR;
         end
         ST_A_POP_WR: begin
            heads_in[slot_o] = next_rdata;
            lens_in[slot_o]  = lens_ff[slot_o] - bba_pkg::len_type'(1);
            live_we          = 1'b1;
            live_waddr       = b_ff;
            live_wdata       = 1'b1;
            ord_we           = 1'b1;
            ord_waddr        = b_ff;
            ord_wdata        = bba_pkg::heap_order_type'(order_ff);
            used_in          = used_ff + used_delta;
            done_in          = 1'b1;
            status_in        = bba_pkg::STATUS_OK;
            offset_in        = {b_ff, bba_pkg::MinBlockOrder'(0)};
            state_in         = ST_IDLE;
         end
         ST_F_CHECK: begin
            if (!live_rdata) begin
               done_in   = 1'b1;
               status_in = bba_pkg::STATUS_BAD_FREE;
               offset_in = '0;
               state_in  = ST_IDLE;
            end else begin
               order_in   = freed_order;
               live_we    = 1'b1;
               live_waddr = unit_ff;
               live_wdata = 1'b0;
               used_in    = used_ff - (bba_pkg::UsedBits'(1) << freed_order);
               state_in   = ST_F_MERGE;
            end
         end
         ST_F_MERGE: begin
            if (order_ff >= top5 || lens_ff[slot_o] == '0) begin
               state_in = ST_F_PUSH;
            end else begin
               cur_in   = heads_ff[slot_o];
               k_in     = '0;
               state_in = ST_F_WALK_RD;
            end
         end
         ST_F_WALK_RD: begin
            next_raddr = cur_ff;
            state_in   = ST_F_WALK;
         end
         ST_F_WALK: begin
            if (cur_ff == bud_unit) begin
               if (k_ff == '0) begin
                  heads_in[slot_o] = next_rdata;
               end else begin
                  next_we    = 1'b1;
                  next_waddr = prev_ff;
                  next_wdata = next_rdata;
               end
               lens_in[slot_o] = lens_ff[slot_o] - bba_pkg::len_type'(1);
               if (bud_unit < unit_ff) begin
                  unit_in = bud_unit;
               end
               order_in = order_ff + bba_pkg::order_type'(1);
               state_in = ST_F_MERGE;
            end else if ((bba_pkg::LenBits+1)'(k_ff) + (bba_pkg::LenBits+1)'(1) >=
                         (bba_pkg::LenBits+1)'(lens_ff[slot_o])) begin
               state_in = ST_F_PUSH;
            end else begin
               prev_in  = cur_ff;
               cur_in   = next_rdata;
               k_in     = k_ff + bba_pkg::len_type'(1);
               state_in = ST_F_WALK_RD;
            end
         end
         ST_F_PUSH: begin
            next_we          = 1'b1;
            next_waddr       = unit_ff;
            next_wdata       = heads_ff[slot_o];
            heads_in[slot_o] = unit_ff;
            lens_in[slot_o]  = lens_ff[slot_o] + bba_pkg::len_type'(1);
            done_in          = 1'b1;
            status_in        = bba_pkg::STATUS_OK;
            offset_in        = '0;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg.write) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
         used_in  = '0;
         done_in  = 1'b0;
         for (int i = 0; i < bba_pkg::OrderSlots; i++) begin
            heads_in[i] = '0;
            lens_in[i]  = '0;
         end
         lens_in[bba_pkg::slot_type'(cfg.top_order - bba_pkg::heap_order_type'(bba_pkg::MinBlockOrder))]
            = bba_pkg::len_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         used_ff  <= '0;
         done_ff  <= 1'b0;
         for (int i = 0; i < bba_pkg::OrderSlots; i++) begin
            heads_ff[i] <= '0;
            lens_ff[i]  <= '0;
         end
         lens_ff[bba_pkg::OrderSlots-1] <= bba_pkg::len_type'(1);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         used_ff  <= used_in;
         done_ff  <= done_in;
         heads_ff <= heads_in;
         lens_ff  <= lens_in;
      end
      req_ff    <= req_in;
      order_ff  <= order_in;
      j_ff      <= j_in;
      unit_ff   <= unit_in;
      b_ff      <= b_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp.done    = done_ff;
   assign rsp.status  = status_ff;
   assign rsp.offset  = offset_ff;
   assign rsp.used    = used_ff;

   `BBA_ASSERT_NEXT(a_start_leaves_idle, clock, reset,
      state_ff == ST_IDLE && start && !cfg.write, state_ff != ST_IDLE || done_ff,
      "Accepted transaction neither started work nor completed.")
   `BBA_ASSERT_IMPLY(a_split_above_order, clock, reset,
      state_ff == ST_A_SPLIT_RD, j_ff > order_ff,
      "Split started at or below the requested order.")
   `BBA_ASSERT_IMPLY(a_used_within_heap, clock, reset,
      !cfg.write, used_ff <= (bba_pkg::UsedBits'(1) << cfg.top_order),
      "Allocated total exceeds the heap size.")

endmodule

>>> hdl/buddy_block_allocator.sv
// Top level of the buddy block allocator: heap order register and port wiring.
// Depends on bba_pkg and bba_seq; assertion macros from the defines header.
`timescale 1ns / 1ps
`include "buddy_block_allocator_defines.svh"

// Channel    Handshake            Payload
// request    start / busy         req_op, req_request_bytes, req_block_offset
// response   rsp_valid (strobe)   rsp_status, rsp_result_offset, rsp_used_bytes
// config     csr_valid/csr_ready  csr_data (heap order)
//
// An allocation steps through sizing, a search of the free lists, a read, write and push
// step per split and a read and write step to pop; a free checks the live mark, reads and
// compares each free-list entry examined by the buddy search, merges per level and pushes.
// After reset and after every heap order write, a pass clears every live mark while busy
// stays high. The response strobe lasts one cycle and cannot be stalled.

module buddy_block_allocator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_op,
   input  logic [bba_pkg::ReqBits-1:0]          req_request_bytes,
   input  logic [bba_pkg::OffsetBits-1:0]       req_block_offset,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [bba_pkg::OffsetBits-1:0]       rsp_result_offset,
   output logic [bba_pkg::UsedBits-1:0]         rsp_used_bytes,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bba_pkg::HeapOrderBits-1:0]    csr_data
);

   bba_pkg::heap_order_type heap_order_ff, heap_order_in;
   bba_pkg::cfg_type        cfg;
   bba_pkg::rsp_type        rsp;

   assign csr_ready     = 1'b1;
   assign heap_order_in = (csr_valid && csr_ready) ? csr_data : heap_order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_order_ff <= bba_pkg::heap_order_type'(bba_pkg::HeapOrderCap);
      end else begin
         heap_order_ff <= heap_order_in;
      end
   end

   assign cfg.write     = csr_valid && csr_ready;
   assign cfg.top_order = bba_pkg::eff_order(heap_order_in);

   bba_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_op            (req_op),
      .req_request_bytes (req_request_bytes),
      .req_block_offset  (req_block_offset),
      .cfg               (cfg),
      .busy              (busy),
      .rsp               (rsp)
   );

   assign rsp_valid         = rsp.done;
   assign rsp_status        = rsp.status;
   assign rsp_result_offset = rsp.offset;
   assign rsp_used_bytes    = rsp.used;

   `BBA_ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid, !busy,
      "Response strobe while a transaction is still in progress.")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the buddy block allocator: random and directed
// allocate/free transactions checked against an in-bench allocator model.
// Depends on bba_pkg and the buddy_block_allocator RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int Units = 1 << bba_pkg::UnitBits;
   localparam int IdleLimit = 40000;

   typedef struct {
      bba_pkg::status_type            status;
      logic [bba_pkg::OffsetBits-1:0] offset;
      logic [bba_pkg::UsedBits-1:0]   used;
   } outcome_type;

   typedef struct {
      logic                           op;
      logic [bba_pkg::ReqBits-1:0]    bytes;
      logic [bba_pkg::OffsetBits-1:0] offs;
      outcome_type                    want;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = bba_pkg::OP_ALLOC;
   logic [bba_pkg::ReqBits-1:0] req_request_bytes = '0;
   logic [bba_pkg::OffsetBits-1:0] req_block_offset = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [bba_pkg::OffsetBits-1:0] rsp_result_offset;
   logic [bba_pkg::UsedBits-1:0] rsp_used_bytes;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bba_pkg::HeapOrderBits-1:0] csr_data = '0;

   request_type pending_requests[$];
   outcome_type awaited_outcomes[$];
   int error_count = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   bit quiet_run = 0;

   // Allocator model state.
   int heap_order_reg;
   int free_head[bba_pkg::OrderSlots];
   int free_len[bba_pkg::OrderSlots];
   int link_next[Units];
   int unit_order[Units];
   bit unit_live[Units];
   int bytes_in_use;
   int live_offsets[$];
   int freed_offsets[$];

   buddy_block_allocator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_request_bytes(req_request_bytes),
      .req_block_offset(req_block_offset), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_result_offset(rsp_result_offset),
      .rsp_used_bytes(rsp_used_bytes), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int heap_top();
      return (heap_order_reg < bba_pkg::MinBlockOrder) ? bba_pkg::MinBlockOrder
                                                       : heap_order_reg;
   endfunction

   function automatic void heap_reinit(input int value);
      heap_order_reg = value;
      for (int s = 0; s < bba_pkg::OrderSlots; s++) begin
         free_head[s] = 0;
         free_len[s] = 0;
      end
      for (int u = 0; u < Units; u++) begin
         link_next[u] = 0;
         unit_order[u] = 0;
         unit_live[u] = 0;
      end
      bytes_in_use = 0;
      free_len[heap_top() - bba_pkg::MinBlockOrder] = 1;
      live_offsets.delete();
      freed_offsets.delete();
   endfunction

   function automatic void list_push(input int slot, input int unit);
      link_next[unit] = free_head[slot];
      free_head[slot] = unit;
      free_len[slot]++;
   endfunction

   function automatic int list_pop(input int slot);
      int b;
      b = free_head[slot];
      free_head[slot] = link_next[b];
      free_len[slot]--;
      return b;
   endfunction

   function automatic bit list_take(input int slot, input int unit);
      int cur;
      int prev;
      cur = free_head[slot];
      prev = 0;
      for (int k = 0; k < free_len[slot]; k++) begin
         if (cur == unit) begin
            if (k == 0) free_head[slot] = link_next[cur];
            else link_next[prev] = link_next[cur];
            free_len[slot]--;
            return 1;
         end
         prev = cur;
         cur = link_next[cur];
      end
      return 0;
   endfunction

   function automatic outcome_type heap_apply(input logic op, input int bytes, input int offs);
      outcome_type r;
      int top;
      int need;
      int order;
      int i;
      int b;
      int unit;
      int o;
      int bud;
      top = heap_top();
      r.status = bba_pkg::STATUS_OK;
      r.offset = '0;
      if (op == bba_pkg::OP_ALLOC) begin
         need = bytes + bba_pkg::HeaderBytes;
         order = bba_pkg::MinBlockOrder;
         while (order < bba_pkg::SizeOrderLimit && (1 << order) < need) order++;
         if (bytes == 0 || order > top) begin
            r.status = bba_pkg::STATUS_BAD_SIZE;
         end else begin
            i = order;
            while (i <= top && free_len[i - bba_pkg::MinBlockOrder] == 0) i++;
            if (i > top) begin
               r.status = bba_pkg::STATUS_NO_MEMORY;
            end else begin
               for (int j = i; j > order; j--) begin
                  b = list_pop(j - bba_pkg::MinBlockOrder);
                  list_push(j - 1 - bba_pkg::MinBlockOrder,
                            b + (1 << (j - 1 - bba_pkg::MinBlockOrder)));
                  list_push(j - 1 - bba_pkg::MinBlockOrder, b);
               end
               b = list_pop(order - bba_pkg::MinBlockOrder);
               unit_live[b] = 1;
               unit_order[b] = order;
               bytes_in_use += 1 << order;
               r.offset = bba_pkg::OffsetBits'(b << bba_pkg::MinBlockOrder);
               live_offsets.push_back(b << bba_pkg::MinBlockOrder);
            end
         end
      end else begin
         unit = (offs >> bba_pkg::MinBlockOrder) & (Units - 1);
         if ((offs & ((1 << bba_pkg::MinBlockOrder) - 1)) != 0 || offs >= (1 << top)
               || !unit_live[unit]) begin
            r.status = bba_pkg::STATUS_BAD_FREE;
         end else begin
            o = unit_order[unit];
            if (o < bba_pkg::MinBlockOrder) o = bba_pkg::MinBlockOrder;
            if (o > top) o = top;
            unit_live[unit] = 0;
            bytes_in_use -= 1 << o;
            foreach (live_offsets[k]) begin
               if (live_offsets[k] == offs) begin
                  live_offsets.delete(k);
                  break;
               end
            end
            freed_offsets.push_back(offs);
            while (o < top) begin
               bud = unit ^ (1 << (o - bba_pkg::MinBlockOrder));
               if (!list_take(o - bba_pkg::MinBlockOrder, bud)) break;
               if (bud < unit) unit = bud;
               o++;
            end
            list_push(o - bba_pkg::MinBlockOrder, unit);
         end
      end
      r.used = bba_pkg::UsedBits'(bytes_in_use);
      return r;
   endfunction

   function automatic void queue_request(input logic op, input int bytes, input int offs);
      request_type t;
      t.op = op;
      t.bytes = bba_pkg::ReqBits'(bytes);
      t.offs = bba_pkg::OffsetBits'(offs);
      t.want = heap_apply(op, int'(t.bytes), int'(t.offs));
      pending_requests.push_back(t);
   endfunction

   function automatic void queue_random_request();
      int pick;
      int size_order;
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
         size_order = bba_pkg::MinBlockOrder
            + $urandom_range(0, heap_top() - bba_pkg::MinBlockOrder)
            * $urandom_range(0, 3) / 3;
         queue_request(bba_pkg::OP_ALLOC,
                       $urandom_range(1, (1 << size_order) - bba_pkg::HeaderBytes), 0);
      end else if (pick < 52) begin
         queue_request(bba_pkg::OP_ALLOC,
                       ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 65535), 0);
      end else if (pick < 88 && live_offsets.size() > 0) begin
         queue_request(bba_pkg::OP_FREE, 0,
                       live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
      end else if (pick < 94 && freed_offsets.size() > 0) begin
         queue_request(bba_pkg::OP_FREE, 0,
                       freed_offsets[$urandom_range(0, freed_offsets.size() - 1)]);
      end else begin
         queue_request(bba_pkg::OP_FREE, $urandom_range(0, 65535), $urandom_range(0, 32767));
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || start || awaited_outcomes.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_heap_order(input int value);
      wait_drained();
      @(posedge clock);
      csr_data <= bba_pkg::HeapOrderBits'(value);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      heap_reinit(value);
   endtask

   always @(posedge clock) begin
      bit taken;
      request_type t;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            awaited_outcomes.push_back(pending_requests.pop_front().want);
         end
         if (!start || taken) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               t = pending_requests[0];
               req_op <= t.op;
               req_request_bytes <= t.bytes;
               req_block_offset <= t.offs;
               start <= 1'b1;
               if ($urandom_range(0, 40) == 0) quiet_run = !quiet_run;
               gap_left = quiet_run ? 0 : $urandom_range(0, 10);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_valid) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("unexpected response count", 1, 0);
         end else begin
            w = awaited_outcomes.pop_front();
            if (rsp_status !== w.status) report_mismatch("status", rsp_status, w.status);
            if (rsp_result_offset !== w.offset)
               report_mismatch("result_offset", rsp_result_offset, w.offset);
            if (rsp_used_bytes !== w.used) report_mismatch("used_bytes", rsp_used_bytes, w.used);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int heap_plan[$];
      heap_plan = '{4, 0, 9, 15, 6, 12, 15};
      heap_reinit(15);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      queue_request(bba_pkg::OP_ALLOC, 0, 0);
      queue_request(bba_pkg::OP_ALLOC, 65535, 0);
      queue_request(bba_pkg::OP_ALLOC, 32760, 0);
      queue_request(bba_pkg::OP_ALLOC, 1, 0);
      queue_request(bba_pkg::OP_FREE, 0, 5);
      queue_request(bba_pkg::OP_FREE, 0, 32752);
      queue_request(bba_pkg::OP_FREE, 0, 0);
      queue_request(bba_pkg::OP_FREE, 0, 0);
      queue_request(bba_pkg::OP_ALLOC, 1, 0);
      queue_request(bba_pkg::OP_ALLOC, 8, 0);
      queue_request(bba_pkg::OP_ALLOC, 9, 0);
      queue_request(bba_pkg::OP_ALLOC, 24, 0);
      queue_request(bba_pkg::OP_FREE, 65535, 16);
      queue_request(bba_pkg::OP_FREE, 0, 0);
      queue_request(bba_pkg::OP_FREE, 0, 32);
      queue_request(bba_pkg::OP_FREE, 0, 64);
      queue_request(bba_pkg::OP_ALLOC, 32761, 0);
      write_heap_order(4);
      queue_request(bba_pkg::OP_ALLOC, 8, 0);
      queue_request(bba_pkg::OP_ALLOC, 9, 0);
      queue_request(bba_pkg::OP_ALLOC, 8, 0);
      queue_request(bba_pkg::OP_FREE, 0, 16);
      queue_request(bba_pkg::OP_FREE, 0, 0);

      foreach (heap_plan[p]) begin
         if (p > 0) write_heap_order(heap_plan[p]);
         repeat (245) queue_random_request();
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_seq.sv
hdl/buddy_block_allocator.sv
tb/tb_top.sv
